// ----- hw/rtl/bitmap_to_tile_memory_scatter_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap to tile memory scatter
// Clocked, reset-qualified property checks used at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef BITMAP_TO_TILE_MEMORY_SCATTER_MACROS_SVH
`define BITMAP_TO_TILE_MEMORY_SCATTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check cons in the same cycle as ante
`define BTMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define BTMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BTMS_ASSERT_SAME(lbl, ante, cons, msg)
`define BTMS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/btms_pkg.sv -----
// ---------------------------------------------------------------------------
// btms_pkg
// Shared constants, register indexes and types of the tile memory scatter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btms_pkg;

  // Sizing
  localparam int MAX_WIDTH        = 2048;
  localparam int MEM_ADDRESS_BITS = 22;
  localparam int DIM_LIMIT        = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam int DIM_W            = 12;
  localparam int CNT_W            = $clog2(DIM_LIMIT);
  localparam int ADDR_SUM_W       = 25;
  localparam int TILE_W           = 16;
  localparam int PAGE_W           = 8;
  localparam int PIX_W            = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PIXELS_4BIT  = 3'd2,
    REG_TOP_DOWN     = 3'd3,
    REG_SPRITE_MODE  = 3'd4,
    REG_FIRST_TILE   = 3'd5,
    REG_DEST_PAGE    = 3'd6
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic              pixels_4bit;
    logic              top_down;
    logic              sprite_mode;
    logic [TILE_W-1:0] first_tile;
    logic [PAGE_W-1:0] dest_page;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:  DIM_W'(256),
    image_height: DIM_W'(256),
    pixels_4bit:  1'b0,
    top_down:     1'b0,
    sprite_mode:  1'b0,
    first_tile:   '0,
    dest_page:    PAGE_W'(7)
  };

endpackage

// ----- hw/rtl/btms_place.sv -----
// ---------------------------------------------------------------------------
// btms_place
// Maps a pixel position to its byte address in 8x8 tile or 16x16 sprite
// memory layout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btms_place (
  input  logic [btms_pkg::CNT_W-1:0]            x,
  input  logic [btms_pkg::CNT_W-1:0]            y,
  input  logic [btms_pkg::DIM_W-1:0]            w,
  input  btms_pkg::cfg_t                        cfg,
  output logic [btms_pkg::MEM_ADDRESS_BITS-1:0] addr
);

  localparam int PROD_W = btms_pkg::CNT_W + btms_pkg::DIM_W;
  localparam int SUM_W  = btms_pkg::ADDR_SUM_W;
  localparam int TW     = btms_pkg::TILE_W;

  logic [btms_pkg::CNT_W-1:0] tile_row;
  logic [btms_pkg::CNT_W-1:0] tile_col;
  logic [btms_pkg::DIM_W-1:0] tiles_w;
  logic [PROD_W-1:0]          prod;
  logic [TW-1:0]              tile;
  logic [SUM_W-1:0]           offset;
  logic [SUM_W-1:0]           sum;

  // Tile coordinates: blocks of 8, or 16 for sprites
  assign tile_row = cfg.sprite_mode ? (y >> 4) : (y >> 3);
  assign tile_col = cfg.sprite_mode ? (x >> 4) : (x >> 3);
  assign tiles_w  = cfg.sprite_mode ? (w >> 4) : (w >> 3);

  // Tile number, modulo 2^16
  assign prod = PROD_W'(tile_row) * PROD_W'(tiles_w);
  assign tile = cfg.first_tile + prod[TW-1:0] + TW'(tile_col);

  // Place within the area: 256-byte lines
  always_comb begin
    if (cfg.sprite_mode) begin
      offset = SUM_W'({tile[TW-1:4], 12'b0}) + SUM_W'({tile[3:0], 4'b0})
             + SUM_W'({y[3:0], 8'b0}) + SUM_W'(x[3:0]);
    end else begin
      offset = SUM_W'({tile[TW-1:5], 11'b0}) + SUM_W'({tile[4:0], 3'b0})
             + SUM_W'({y[2:0], 8'b0}) + SUM_W'(x[2:0]);
    end
  end

  // Add page base and wrap to the memory size
  assign sum  = SUM_W'({cfg.dest_page, 14'b0}) + offset;
  assign addr = sum[btms_pkg::MEM_ADDRESS_BITS-1:0];

endmodule

// ----- hw/rtl/bitmap_to_tile_memory_scatter.sv -----
// ---------------------------------------------------------------------------
// bitmap_to_tile_memory_scatter
// Turns bitmap pixel bytes in file order into tile memory writes.
// ---------------------------------------------------------------------------
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_ready, in_pixel_byte             | sink
//   out     | out_valid, out_ready, out_mem_address,        | source
//           | out_pixel_value, out_last_of_item,            |
//           | out_image_done                                |
//   cfg     | cfg_we, cfg_index, cfg_data                   | sink
//
// 8-bit pixels: one byte per cycle while the output is not stalled; 4-bit
// pixels outside sprite mode: two writes per byte on the single output port.
// The first write of a byte goes from the input register through the address
// logic (one small multiply and adds) into the output register. A synchronous
// reset restores the counters, the state flags and the configuration; the data
// registers are not reset.
// A stalled output holds its write while the next byte waits in the input
// register. In 4-bit mode a byte stays in the input register for both of its
// writes, so the input also stalls while the high nibble goes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_to_tile_memory_scatter_macros.svh"

module bitmap_to_tile_memory_scatter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [btms_pkg::PIX_W-1:0]            in_pixel_byte,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [btms_pkg::MEM_ADDRESS_BITS-1:0] out_mem_address,
  output logic [btms_pkg::PIX_W-1:0]            out_pixel_value,
  output logic                                  out_last_of_item,
  output logic                                  out_image_done,
  // configuration
  input  logic                                  cfg_we,
  input  logic [btms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [btms_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CW = btms_pkg::CNT_W;
  localparam int DW = btms_pkg::DIM_W;
  localparam logic [DW-1:0] LIM = DW'(btms_pkg::DIM_LIMIT);

  // Registers
  btms_pkg::cfg_t cfg_r;

  logic [CW-1:0]  col_r, col_nxt;
  logic [CW-1:0]  row_r, row_nxt;

  logic                       s1_valid_r;
  logic                       s1_half_r;
  logic                       s1_nib_r;
  logic                       s1_done_r;
  logic [btms_pkg::PIX_W-1:0] s1_byte_r;
  logic [CW-1:0]              s1_x_r;
  logic [CW-1:0]              s1_y_r;
  logic [DW-1:0]              s1_w_r;

  logic                                  out_valid_r;
  logic [btms_pkg::MEM_ADDRESS_BITS-1:0] out_addr_r;
  logic [btms_pkg::PIX_W-1:0]            out_pix_r;
  logic                                  out_last_r;
  logic                                  out_done_r;

  // Image geometry from configuration
  logic          nib;
  logic [DW-1:0] w_lim, h_lim, w_al, h_al, w_eff, h_eff, unit, row_bytes;
  logic [CW-1:0] col, row;
  logic [DW-1:0] y_full;
  logic          row_end, done;
  logic          in_accept;

  // Output side
  logic                                  out_load;
  logic                                  s1_last_beat;
  logic [CW-1:0]                         place_x;
  logic [btms_pkg::MEM_ADDRESS_BITS-1:0] place_addr;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= btms_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        btms_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[DW-1:0];
        btms_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[DW-1:0];
        btms_pkg::REG_PIXELS_4BIT:  cfg_r.pixels_4bit  <= cfg_data[0];
        btms_pkg::REG_TOP_DOWN:     cfg_r.top_down     <= cfg_data[0];
        btms_pkg::REG_SPRITE_MODE:  cfg_r.sprite_mode  <= cfg_data[0];
        btms_pkg::REG_FIRST_TILE:   cfg_r.first_tile   <= cfg_data[btms_pkg::TILE_W-1:0];
        btms_pkg::REG_DEST_PAGE:    cfg_r.dest_page    <= cfg_data[btms_pkg::PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp and align the image size
  assign unit  = cfg_r.sprite_mode ? DW'(16) : DW'(8);
  assign w_lim = (cfg_r.image_width  > LIM) ? LIM : cfg_r.image_width;
  assign h_lim = (cfg_r.image_height > LIM) ? LIM : cfg_r.image_height;
  assign w_al  = cfg_r.sprite_mode ? {w_lim[DW-1:4], 4'b0} : {w_lim[DW-1:3], 3'b0};
  assign h_al  = cfg_r.sprite_mode ? {h_lim[DW-1:4], 4'b0} : {h_lim[DW-1:3], 3'b0};
  assign w_eff = (w_al < unit) ? unit : w_al;
  assign h_eff = (h_al < unit) ? unit : h_al;

  assign nib       = cfg_r.pixels_4bit && !cfg_r.sprite_mode;
  assign row_bytes = nib ? (w_eff >> 1) : w_eff;

  // Restart counters left out of range, then find the row and edges
  assign col     = (DW'(col_r) >= row_bytes) ? '0 : col_r;
  assign row     = (DW'(row_r) >= h_eff) ? '0 : row_r;
  assign y_full  = cfg_r.top_down ? DW'(row) : (h_eff - DW'(1) - DW'(row));
  assign row_end = (DW'(col) + DW'(1)) >= row_bytes;
  assign done    = row_end && ((DW'(row) + DW'(1)) >= h_eff);

  // Advance the column and row counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = done ? '0 : row + CW'(1);
      end else begin
        col_nxt = col + CW'(1);
        row_nxt = row;
      end
    end
  end

  // Handshake
  assign s1_last_beat = !s1_nib_r || s1_half_r;
  assign out_load     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || (out_load && s1_last_beat);
  assign in_accept    = in_valid && in_ready;

  // Input register: hold one byte with its position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_half_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        s1_half_r  <= 1'b0;
      end else if (out_load && s1_last_beat) begin
        s1_valid_r <= 1'b0;
      end else if (out_load) begin
        s1_half_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_pixel_byte;
      s1_nib_r  <= nib;
      s1_done_r <= done;
      s1_x_r    <= nib ? (col << 1) : col;
      s1_y_r    <= y_full[CW-1:0];
      s1_w_r    <= w_eff;
    end
  end

  // Address of the current pixel
  assign place_x = {s1_x_r[CW-1:1], s1_x_r[0] | s1_half_r};

  btms_place u_place (
    .x    (place_x),
    .y    (s1_y_r),
    .w    (s1_w_r),
    .cfg  (cfg_r),
    .addr (place_addr)
  );

  // Output register: one write word per cycle while out_ready does not stall it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr_r <= place_addr;
      out_last_r <= s1_last_beat;
      out_done_r <= s1_last_beat && s1_done_r;
      if (!s1_nib_r) begin
        out_pix_r <= s1_byte_r;
      end else if (s1_half_r) begin
        out_pix_r <= {4'b0, s1_byte_r[3:0]};
      end else begin
        out_pix_r <= {4'b0, s1_byte_r[7:4]};
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mem_address  = out_addr_r;
  assign out_pixel_value  = out_pix_r;
  assign out_last_of_item = out_last_r;
  assign out_image_done   = out_done_r;

  // Checks
  `BTMS_ASSERT_SAME(a_done_is_last, out_valid && out_image_done, out_last_of_item, "image done on a word that is not last of its byte")
  `BTMS_ASSERT_NEXT(a_low_nibble_follows, out_valid && out_ready && !out_last_of_item, out_valid, "low nibble write did not follow the high nibble")
  `BTMS_ASSERT_SAME(a_half_only_nib, s1_valid_r && s1_half_r, s1_nib_r, "second beat pending on an 8-bit pixel")
  `BTMS_ASSERT_NEXT(a_counters_wrap, in_accept && done, (col_r == '0) && (row_r == '0), "counters not cleared after the last byte of the image")

endmodule
